// ===== hdl/gbnr_pkg.sv =====
// Package with the item types and verdict codes of the Go-Back-N receiver.
package gbnr_pkg;

  // Verdict codes carried on each acknowledgement.
  typedef enum logic [1:0] {
    VERDICT_OK      = 2'd0,
    VERDICT_CORRUPT = 2'd1,
    VERDICT_ORDER   = 2'd2
  } verdict_t;

  // One input item: header words are only meaningful with first_item.
  typedef struct packed {
    logic               first_item;
    logic               last_item;
    logic signed [31:0] seq_word;
    logic signed [31:0] ack_word;
    logic signed [31:0] check_word;
    logic signed [7:0]  payload_byte;
  } in_item_t;

  // One acknowledgement item.
  typedef struct packed {
    logic signed [31:0] ack_number;
    logic signed [31:0] ack_check;
    verdict_t           verdict;
  } out_item_t;

  // Packet snapshot handed from the accumulator to the decision stage.
  typedef struct packed {
    logic [31:0] seq;
    logic [31:0] hdr_sum;
    logic [31:0] check;
    logic [31:0] pay_sum;
  } snap_t;

endpackage

// ===== hdl/gbnr_accum.sv =====
// Packet accumulator: latches the header and sums payload bytes up to the first zero, within the payload size.
module gbnr_accum #(
  parameter int PAYLOAD_BYTES = 20
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  gbnr_pkg::in_item_t in_item,
  output logic              snap_valid,
  input  logic              snap_take,
  output gbnr_pkg::snap_t   snap
);

  localparam int CW = $clog2(PAYLOAD_BYTES + 1);

  logic [31:0]      held_seq_r, held_seq_nxt;
  logic [31:0]      held_ack_r, held_ack_nxt;
  logic [31:0]      held_check_r, held_check_nxt;
  logic [31:0]      sum_r, sum_nxt;
  logic             zero_r, zero_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             snap_valid_r, snap_valid_nxt;
  gbnr_pkg::snap_t  snap_r, snap_nxt;

  logic             fire;
  logic [31:0]      add_sum;
  logic             add_zero;
  logic [CW-1:0]    add_cnt;
  logic [7:0]       pbyte;

  // A pending snapshot that cannot move on holds off new items.
  assign in_stall = snap_valid_r && !snap_take;
  assign fire     = in_valid && !in_stall;
  assign pbyte    = in_item.payload_byte;

  // Header latch, byte accumulation and snapshot on the last item.
  always_comb begin
    held_seq_nxt   = held_seq_r;
    held_ack_nxt   = held_ack_r;
    held_check_nxt = held_check_r;
    sum_nxt        = sum_r;
    zero_nxt       = zero_r;
    cnt_nxt        = cnt_r;
    snap_nxt       = snap_r;
    snap_valid_nxt = snap_take ? 1'b0 : snap_valid_r;
    add_sum        = sum_r;
    add_zero       = zero_r;
    add_cnt        = cnt_r;
    if (fire) begin
      // A first item restarts the packet with fresh header words.
      if (in_item.first_item) begin
        held_seq_nxt   = in_item.seq_word;
        held_ack_nxt   = in_item.ack_word;
        held_check_nxt = in_item.check_word;
        add_sum        = '0;
        add_zero       = 1'b0;
        add_cnt        = '0;
      end
      // Bytes beyond the payload size and after a zero are not summed.
      if (add_cnt < CW'(PAYLOAD_BYTES)) begin
        add_cnt = add_cnt + CW'(1);
        if (!add_zero) begin
          if (pbyte == 8'd0) begin
            add_zero = 1'b1;
          end else begin
            add_sum = add_sum + {{24{pbyte[7]}}, pbyte};
          end
        end
      end
      sum_nxt  = add_sum;
      zero_nxt = add_zero;
      cnt_nxt  = add_cnt;
      if (in_item.last_item) begin
        snap_nxt.seq     = held_seq_nxt;
        snap_nxt.hdr_sum = held_seq_nxt + held_ack_nxt;
        snap_nxt.check   = held_check_nxt;
        snap_nxt.pay_sum = add_sum;
        snap_valid_nxt   = 1'b1;
        sum_nxt          = '0;
        zero_nxt         = 1'b0;
        cnt_nxt          = '0;
      end
    end
  end

  // State registers; the snapshot payload needs no reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_seq_r   <= '0;
      held_ack_r   <= '0;
      held_check_r <= '0;
      sum_r        <= '0;
      zero_r       <= 1'b0;
      cnt_r        <= '0;
      snap_valid_r <= 1'b0;
    end else begin
      held_seq_r   <= held_seq_nxt;
      held_ack_r   <= held_ack_nxt;
      held_check_r <= held_check_nxt;
      sum_r        <= sum_nxt;
      zero_r       <= zero_nxt;
      cnt_r        <= cnt_nxt;
      snap_valid_r <= snap_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    snap_r <= snap_nxt;
  end

  assign snap_valid = snap_valid_r;
  assign snap       = snap_r;

endmodule

// ===== hdl/gbnr_decide.sv =====
// Decision stage: checks the packet, forms the acknowledgement and tracks the window.
module gbnr_decide #(
  parameter int SEQ_SPACE = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                snap_valid,
  output logic                snap_take,
  input  gbnr_pkg::snap_t     snap,
  output logic                out_valid,
  input  logic                out_stall,
  output gbnr_pkg::out_item_t out_item
);

  localparam int SW = $clog2(SEQ_SPACE);

  logic [SW-1:0]       exp_r, exp_nxt;
  logic                out_valid_r, out_valid_nxt;
  gbnr_pkg::out_item_t out_r, out_nxt;

  logic [31:0]         total;
  logic [31:0]         exp_ext;
  logic [31:0]         ackn;

  // The output register takes a new result when empty or being drained.
  assign snap_take = snap_valid && (!out_valid_r || !out_stall);
  assign total     = snap.hdr_sum + snap.pay_sum;
  assign exp_ext   = 32'(exp_r);

  // Classify the packet and build the acknowledgement.
  always_comb begin
    exp_nxt       = exp_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    ackn          = snap.seq;
    if (snap_take) begin
      out_valid_nxt = 1'b1;
      if (total != snap.check) begin
        ackn              = snap.seq - 32'd1;
        out_nxt.ack_check = ackn + snap.pay_sum;
        out_nxt.verdict   = gbnr_pkg::VERDICT_CORRUPT;
      end else if (snap.seq != exp_ext) begin
        // The window wraps below zero to its top sequence number.
        if (exp_r == '0) begin
          ackn = 32'(SEQ_SPACE - 1);
        end else begin
          ackn = exp_ext - 32'd1;
        end
        out_nxt.ack_check = ackn + snap.pay_sum;
        out_nxt.verdict   = gbnr_pkg::VERDICT_ORDER;
      end else begin
        ackn              = snap.seq;
        out_nxt.ack_check = ackn;
        out_nxt.verdict   = gbnr_pkg::VERDICT_OK;
        if (exp_r == SW'(SEQ_SPACE - 1)) begin
          exp_nxt = '0;
        end else begin
          exp_nxt = exp_r + SW'(1);
        end
      end
      out_nxt.ack_number = ackn;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      exp_r       <= exp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// ===== hdl/go_back_n_receiver_ack_top.sv =====
// Top level of the Go-Back-N receiver acknowledgement block.
//
// Usage: packets arrive on the in_ channel as runs of items, one payload byte
// per item; the item with first_item set also carries the sequence, ack and
// checksum words. Each item marked last_item produces exactly one
// acknowledgement on the out_ channel; other items produce nothing.
// Both channels use valid/stall: an item moves on a rising edge with valid
// high and stall low.
// Throughput: one item per cycle while in_stall is low, set by the byte
// accumulator, which adds one byte per cycle. The accumulator snapshot is
// written at the edge that accepts the last item, and the decision register
// takes it once that register is empty or being drained.
// While out_stall holds a result, one more finished packet can wait in the
// snapshot register; once that register is occupied and cannot move on,
// in_stall rises and holds off every further item until the result drains.
// Reset (rst_n low, synchronous) clears the expected sequence, the latched
// header words and the accumulator, and empties both pipeline registers.
module go_back_n_receiver_ack_top #(
  parameter int SEQ_SPACE     = 4,
  parameter int PAYLOAD_BYTES = 20
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  gbnr_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output gbnr_pkg::out_item_t out_item
);

  logic            snap_valid;
  logic            snap_take;
  gbnr_pkg::snap_t snap;

  // Header latch and payload summation.
  gbnr_accum #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .snap_valid(snap_valid),
    .snap_take (snap_take),
    .snap      (snap)
  );

  // Checksum and sequence check, acknowledgement output register.
  gbnr_decide #(
    .SEQ_SPACE(SEQ_SPACE)
  ) u_decide (
    .clk       (clk),
    .rst_n     (rst_n),
    .snap_valid(snap_valid),
    .snap_take (snap_take),
    .snap      (snap),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the Go-Back-N receiver acknowledgement block.
`timescale 1ns / 1ps

module tb_top;

  localparam int SEQ_SPACE     = 4;
  localparam int PAYLOAD_BYTES = 20;
  localparam int TOTAL_ITEMS   = 1720;
  localparam int PAUSE_EVERY   = 500;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 500000;

  typedef logic signed [7:0] pay_q_t[$];

  // Predicts the acknowledgement of each packet and checks the ones that come out.
  class ack_scoreboard;
    logic [31:0]         next_seq;
    logic [31:0]         sum_acc;
    bit                  zero_hit;
    int unsigned         bytes_in;
    logic [31:0]         hdr_seq;
    logic [31:0]         hdr_ack;
    logic [31:0]         hdr_check;
    gbnr_pkg::out_item_t pending_acks[$];
    int unsigned         mismatches;
    int unsigned         acks_checked;
    int unsigned         verdict_hits[0:2];

    function new();
      next_seq  = '0;
      hdr_seq   = '0;
      hdr_ack   = '0;
      hdr_check = '0;
      sum_acc   = '0;
      zero_hit  = 1'b0;
      bytes_in  = 0;
    endfunction

    function void note_failure(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%0t mismatch: %s", $realtime, msg);
    endfunction

    // Advances the packet state by one accepted item and queues any acknowledgement.
    function void note_input(gbnr_pkg::in_item_t it);
      logic [31:0]         total;
      gbnr_pkg::out_item_t ack_item;
      if (it.first_item) begin
        hdr_seq   = it.seq_word;
        hdr_ack   = it.ack_word;
        hdr_check = it.check_word;
        sum_acc   = '0;
        zero_hit  = 1'b0;
        bytes_in  = 0;
      end
      // Bytes beyond the payload size and bytes after a zero do not count.
      if (bytes_in < PAYLOAD_BYTES) begin
        bytes_in++;
        if (!zero_hit) begin
          if (it.payload_byte == 8'sd0) zero_hit = 1'b1;
          else sum_acc += {{24{it.payload_byte[7]}}, it.payload_byte};
        end
      end
      if (!it.last_item) return;
      total = hdr_seq + hdr_ack + sum_acc;
      if (total != hdr_check) begin
        ack_item.ack_number = hdr_seq - 32'd1;
        ack_item.ack_check  = hdr_seq - 32'd1 + sum_acc;
        ack_item.verdict    = gbnr_pkg::VERDICT_CORRUPT;
      end else if (hdr_seq != next_seq) begin
        ack_item.ack_number = (next_seq == 0) ? 32'(SEQ_SPACE - 1) : next_seq - 32'd1;
        ack_item.ack_check  = ack_item.ack_number + sum_acc;
        ack_item.verdict    = gbnr_pkg::VERDICT_ORDER;
      end else begin
        ack_item.ack_number = hdr_seq;
        ack_item.ack_check  = hdr_seq;
        ack_item.verdict    = gbnr_pkg::VERDICT_OK;
        next_seq = (next_seq + 1 >= SEQ_SPACE) ? '0 : next_seq + 32'd1;
      end
      pending_acks.push_back(ack_item);
      sum_acc  = '0;
      zero_hit = 1'b0;
      bytes_in = 0;
    endfunction

    // Compares one acknowledgement with the oldest prediction.
    function void check_result(gbnr_pkg::out_item_t got);
      gbnr_pkg::out_item_t want;
      if (pending_acks.size() == 0) begin
        note_failure($sformatf("unexpected ack number=%h check=%h verdict=%0d",
                               got.ack_number, got.ack_check, got.verdict));
        return;
      end
      want = pending_acks.pop_front();
      acks_checked++;
      if (want.verdict <= gbnr_pkg::VERDICT_ORDER) verdict_hits[want.verdict]++;
      if (got.ack_number !== want.ack_number || got.ack_check !== want.ack_check ||
          got.verdict !== want.verdict)
        note_failure($sformatf("ack %0d expected number=%h check=%h verdict=%0d, got %h %h %0d",
                               acks_checked, want.ack_number, want.ack_check, want.verdict,
                               got.ack_number, got.ack_check, got.verdict));
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  gbnr_pkg::in_item_t  in_item;
  logic                out_valid;
  logic                out_stall;
  gbnr_pkg::out_item_t out_item;

  ack_scoreboard sb = new();
  int unsigned   items_sent;
  int unsigned   cycle_count;
  bit            burst;

  go_back_n_receiver_ack_top #(
    .SEQ_SPACE    (SEQ_SPACE),
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Run watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top: run timed out after %0d cycles", cycle_count);
      $display("tb_top: errors");
      $finish;
    end
  end

  // Idle lengths: mostly none or short, now and then long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Receiver back-pressure, with stall-free stretches in between.
  initial begin
    out_stall = 1'b0;
    forever begin
      if ($urandom_range(0, 9) < 3) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(20, 80)) @(posedge clk);
      end else if ($urandom_range(0, 1) == 0) begin
        out_stall <= 1'b1;
        repeat (gap_len() + 1) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
    end
  end

  // Results are taken where valid is high and stall low ahead of the next edge.
  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_item);
  end

  // Offers one item, waits for it to be taken, then idles for a random gap unless in burst mode.
  task automatic send_item(input gbnr_pkg::in_item_t it);
    int idle;
    in_valid <= 1'b1;
    in_item  <= it;
    forever begin
      @(negedge clk);
      if (!in_stall) break;
      @(posedge clk);
    end
    sb.note_input(it);
    @(posedge clk);
    items_sent++;
    idle = burst ? 0 : gap_len();
    if (idle > 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
  endtask

  task automatic go_idle();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (sb.pending_acks.size() != 0) @(posedge clk);
  endtask

  // Sends a run of payload bytes; the header rides on the first item only.
  task automatic send_packet(input pay_q_t body, input logic [31:0] seq, input logic [31:0] ack,
                             input logic [31:0] check, input bit with_first, input bit with_last);
    gbnr_pkg::in_item_t it;
    for (int i = 0; i < body.size(); i++) begin
      it.first_item   = with_first && (i == 0);
      it.last_item    = with_last && (i == body.size() - 1);
      it.seq_word     = it.first_item ? seq : $urandom();
      it.ack_word     = it.first_item ? ack : $urandom();
      it.check_word   = it.first_item ? check : $urandom();
      it.payload_byte = body[i];
      send_item(it);
    end
  endtask

  // Sum of the bytes that the checksum covers.
  function automatic logic [31:0] payload_sum(pay_q_t body);
    logic [31:0] acc;
    acc = '0;
    for (int i = 0; i < body.size() && i < PAYLOAD_BYTES; i++) begin
      if (body[i] == 8'sd0) break;
      acc += {{24{body[i][7]}}, body[i]};
    end
    return acc;
  endfunction

  function automatic pay_q_t random_body(int len, int zero_pct);
    pay_q_t body;
    int     r;
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (r < zero_pct) body.push_back(8'sd0);
      else if (r < zero_pct + 8) body.push_back($urandom_range(0, 1) ? -8'sd128 : 8'sd127);
      else body.push_back(8'($urandom_range(0, 255)));
    end
    return body;
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return $urandom_range(1, 2);
    if (r < 88) return $urandom_range(3, PAYLOAD_BYTES);
    return $urandom_range(PAYLOAD_BYTES + 1, PAYLOAD_BYTES + 6);
  endfunction

  // Main sequence: reset, directed packets, random traffic, wind-down.
  initial begin
    pay_q_t      body;
    logic [31:0] seq;
    logic [31:0] ack;
    logic [31:0] check;
    int          kind;
    int          r;
    int unsigned next_pause;

    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_item     = '0;
    items_sent  = 0;
    cycle_count = 0;
    burst       = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // A stray byte and a headerless last item, summing to zero on the reset header.
    send_packet('{8'sd5}, '0, '0, '0, 1'b0, 1'b0);
    send_packet('{-8'sd5}, '0, '0, '0, 1'b0, 1'b1);
    // Single-item packets: good with extreme words, corrupt with wrap, out of order.
    send_packet('{8'sd127}, 32'd1, 32'h7fff_ffff, 32'd1 + 32'h7fff_ffff + 32'd127, 1'b1, 1'b1);
    send_packet('{-8'sd128}, 32'h8000_0000, 32'hffff_ffff, '0, 1'b1, 1'b1);
    send_packet('{8'sd0}, 32'd3, '0, 32'd3, 1'b1, 1'b1);
    // Full packet with a zero inside and one byte past the payload size.
    body = '{8'sd1, -8'sd128, 8'sd127, -8'sd1, 8'sd64, 8'sd33, -8'sd7, 8'sd12, 8'sd99,
             -8'sd50, 8'sd3, 8'sd4, 8'sd5, 8'sd6, 8'sd0, 8'sd9, 8'sd9, 8'sd9, 8'sd9, 8'sd9,
             -8'sd100};
    send_packet(body, 32'd2, 32'd77, 32'd2 + 32'd77 + payload_sum(body), 1'b1, 1'b1);
    // A header abandoned by a fresh first item, then the wrap of the expected sequence.
    send_packet('{8'sd10, 8'sd20}, 32'd3, '0, '0, 1'b1, 1'b0);
    send_packet('{8'sd1}, 32'd3, 32'd0, 32'd4, 1'b1, 1'b1);
    send_packet('{8'sd2}, 32'd1, 32'd0, 32'd3, 1'b1, 1'b1);
    go_idle();
    wait_drained();

    // Random traffic: mostly well-formed packets, some broken runs.
    next_pause = items_sent + PAUSE_EVERY;
    while (items_sent < TOTAL_ITEMS) begin
      burst = ($urandom_range(0, 9) < 2);
      kind  = $urandom_range(0, 99);
      body  = random_body(pick_len(), $urandom_range(0, 15));
      r = $urandom_range(0, 9);
      if (r < 7) seq = sb.next_seq;
      else if (r < 9) seq = $urandom_range(0, SEQ_SPACE - 1);
      else seq = $urandom();
      ack   = $urandom_range(0, 1) ? 32'($urandom_range(0, 15)) : 32'($urandom());
      check = seq + ack + payload_sum(body);
      r = $urandom_range(0, 9);
      if (r == 0) check = $urandom();
      else if (r == 1) check = $urandom_range(0, 1) ? check + 32'd1 : check - 32'd1;
      if (kind < 82) send_packet(body, seq, ack, check, 1'b1, 1'b1);
      else if (kind < 89) send_packet(body, seq, ack, check, 1'b1, 1'b0);
      else if (kind < 95) send_packet(body, seq, ack, check, 1'b0, 1'b1);
      else send_packet(random_body($urandom_range(1, 3), 20), seq, ack, check, 1'b0, 1'b0);
      // Hold the sender back now and then until every acknowledgement is in.
      if (items_sent >= next_pause) begin
        go_idle();
        wait_drained();
        next_pause = items_sent + PAUSE_EVERY;
      end
    end

    go_idle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.pending_acks.size() != 0)
      sb.note_failure($sformatf("%0d acknowledgements never arrived", sb.pending_acks.size()));

    $display("tb_top: %0d items sent, %0d acknowledgements checked in %0d cycles",
             items_sent, sb.acks_checked, cycle_count);
    $display("tb_top: verdicts accepted=%0d corrupt=%0d out-of-order=%0d, %0d mismatches",
             sb.verdict_hits[0], sb.verdict_hits[1], sb.verdict_hits[2], sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
